// File: rtl/fqs_pkg.sv
package fqs_pkg;

	localparam int DEPTH_DEF   = 16;
	localparam int MAX_RESULTS = 16;
	localparam int VAL_W       = 32;
	localparam int POS_W       = 4;
	localparam int REQ_W       = 2;
	localparam int STATUS_W    = 3;

	typedef enum logic [REQ_W-1:0] {
		REQ_ENQ    = 2'd0,
		REQ_DEQ    = 2'd1,
		REQ_SEARCH = 2'd2
	} req_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 3'd0,
		ST_EMPTY    = 3'd1,
		ST_FULL     = 3'd2,
		ST_FOUND    = 3'd3,
		ST_NOTFOUND = 3'd4
	} status_t;

endpackage

// File: rtl/fqs_ram.sv
module fqs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

// File: rtl/fifo_queue_with_search.sv
// Bounded FIFO of signed 32-bit values with a linear search. Enqueue and
// dequeue produce one response each; an unused request code produces none.
// A search walks the queue from head to tail through the single registered
// read port of the entry RAM, reading then comparing each entry, closes the
// run in a final state, waits while the response side stalls and ends early
// after MAX_RESULTS matches. One found response is given per match with its
// position from the head, or one not-found response (an empty queue gives an
// empty response); last marks the final response of each request. The request
// side is stalled for the whole search and while a response waits to be taken.
module fifo_queue_with_search
	import fqs_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_stall,
	input  logic [REQ_W-1:0]           req_type,
	input  logic signed [VAL_W-1:0]    value,
	output logic                       rsp_valid,
	input  logic                       rsp_stall,
	output logic [STATUS_W-1:0]        status,
	output logic [POS_W-1:0]           position,
	output logic                       last
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int SUM_W = CNT_W + 1;
	localparam int NM_W  = $clog2(MAX_RESULTS + 1);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_READ  = 4'b0010,
		S_CMP   = 4'b0100,
		S_FINAL = 4'b1000
	} state_t;

	state_t              state_q;
	logic [PTR_W-1:0]    head_q;
	logic [CNT_W-1:0]    fill_q;
	logic [VAL_W-1:0]    key_q;
	logic [CNT_W-1:0]    idx_q;
	logic [POS_W-1:0]    pos_q;
	logic [PTR_W-1:0]    rd_addr_q;
	logic                pend_q;
	logic [POS_W-1:0]    pend_pos_q;
	logic [NM_W-1:0]     nmatch_q;

	logic                out_valid_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [POS_W-1:0]    out_pos_q;
	logic                out_last_q;

	logic                slot_free;
	logic                req_acc;
	logic                wr_en;
	logic [PTR_W-1:0]    wr_addr;
	logic [VAL_W-1:0]    rd_data;
	logic                hit;
	logic                last_entry;
	logic                cap;
	logic [SUM_W-1:0]    wr_sum;

	logic                emit;
	logic [STATUS_W-1:0] emit_status;
	logic [POS_W-1:0]    emit_pos;

	assign slot_free = !out_valid_q || !rsp_stall;
	assign req_stall = (state_q != S_IDLE) || !slot_free;
	assign req_acc   = req_valid && !req_stall;

	assign wr_sum  = SUM_W'(head_q) + SUM_W'(fill_q);
	assign wr_addr = (wr_sum >= SUM_W'(DEPTH)) ? PTR_W'(wr_sum - SUM_W'(DEPTH))
	                                           : PTR_W'(wr_sum);
	assign wr_en   = req_acc && (req_type == REQ_ENQ) && (fill_q != CNT_W'(DEPTH));

	fqs_ram #(
		.WIDTH(VAL_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (value),
		.rd_addr (rd_addr_q),
		.rd_data (rd_data)
	);

	assign hit        = (rd_data == key_q);
	assign last_entry = ((idx_q + CNT_W'(1)) == fill_q);
	assign cap        = ((nmatch_q + NM_W'(1)) == NM_W'(MAX_RESULTS));

	always_comb begin
		emit        = 1'b0;
		emit_status = ST_OK;
		emit_pos    = '0;
		case (state_q)
			S_IDLE: begin
				if (req_acc) begin
					case (req_type)
						REQ_ENQ: begin
							emit        = 1'b1;
							emit_status = (fill_q == CNT_W'(DEPTH)) ? ST_FULL : ST_OK;
						end
						REQ_DEQ: begin
							emit        = 1'b1;
							emit_status = (fill_q == '0) ? ST_EMPTY : ST_OK;
						end
						REQ_SEARCH: begin
							if (fill_q == '0) begin
								emit        = 1'b1;
								emit_status = ST_EMPTY;
							end
						end
						default: begin
							emit = 1'b0;
						end
					endcase
				end
			end
			S_CMP: begin
				if (hit && pend_q && slot_free) begin
					emit        = 1'b1;
					emit_status = ST_FOUND;
					emit_pos    = pend_pos_q;
				end
			end
			S_FINAL: begin
				if (slot_free) begin
					emit        = 1'b1;
					emit_status = pend_q ? ST_FOUND : ST_NOTFOUND;
					emit_pos    = pend_q ? pend_pos_q : '0;
				end
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
			pend_q      <= 1'b0;
			nmatch_q    <= '0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_acc) begin
						case (req_type)
							REQ_ENQ: begin
								if (fill_q != CNT_W'(DEPTH)) begin
									fill_q <= fill_q + CNT_W'(1);
								end
							end
							REQ_DEQ: begin
								if (fill_q != '0) begin
									fill_q <= fill_q - CNT_W'(1);
									head_q <= (head_q == PTR_W'(DEPTH - 1)) ? '0
									                                        : head_q + PTR_W'(1);
								end
							end
							REQ_SEARCH: begin
								if (fill_q != '0) begin
									pend_q   <= 1'b0;
									nmatch_q <= '0;
									state_q  <= S_READ;
								end
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_READ: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (!(hit && pend_q && !slot_free)) begin
						if (hit) begin
							pend_q   <= 1'b1;
							nmatch_q <= nmatch_q + NM_W'(1);
						end
						if (last_entry || (hit && cap)) begin
							state_q <= S_FINAL;
						end else begin
							state_q <= S_READ;
						end
					end
				end
				S_FINAL: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_status_q <= emit_status;
			out_pos_q    <= emit_pos;
			out_last_q   <= (state_q != S_CMP);
		end
		case (state_q)
			S_IDLE: begin
				key_q     <= value;
				idx_q     <= '0;
				pos_q     <= '0;
				rd_addr_q <= head_q;
			end
			S_CMP: begin
				if (!(hit && pend_q && !slot_free)) begin
					if (hit) begin
						pend_pos_q <= pos_q;
					end
					idx_q     <= idx_q + CNT_W'(1);
					pos_q     <= pos_q + POS_W'(1);
					rd_addr_q <= (rd_addr_q == PTR_W'(DEPTH - 1)) ? '0
					                                              : rd_addr_q + PTR_W'(1);
				end
			end
			default: begin
				key_q <= key_q;
			end
		endcase
	end

	assign rsp_valid = out_valid_q;
	assign status    = out_status_q;
	assign position  = out_pos_q;
	assign last      = out_last_q;

endmodule

// File: rtl/fqs_checker.sv
module fqs_checker
	import fqs_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    req_valid,
	input  logic                    req_stall,
	input  logic [REQ_W-1:0]        req_type,
	input  logic                    rsp_valid,
	input  logic                    rsp_stall,
	input  logic [STATUS_W-1:0]     status,
	input  logic [POS_W-1:0]        position,
	input  logic                    last
);

	logic req_acc;

	assign req_acc = req_valid && !req_stall;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(status) && $stable(position)
			&& $stable(last))
		else $error("response changed while stalled");

	a_single_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc && (req_type == REQ_ENQ || req_type == REQ_DEQ)
			|=> rsp_valid && last && !req_stall == !rsp_stall)
		else $error("enqueue or dequeue did not give one final response");

	a_pos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != ST_FOUND |-> position == '0)
		else $error("position set on a response that is not a match");

	a_final_codes: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status == ST_OK || status == ST_EMPTY || status == ST_FULL
			|| status == ST_NOTFOUND) |-> last)
		else $error("single-response status without last");

	a_search_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc && req_type == REQ_SEARCH |=> req_stall || rsp_valid)
		else $error("search transaction left no trace");

endmodule

bind fifo_queue_with_search fqs_checker u_fqs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.req_type  (req_type),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.status    (status),
	.position  (position),
	.last      (last)
);
